### rtl/core/wsts_pkg.sv
// Shared types and constants for the work-stealing task scheduler.
// No dependencies; every other file imports this package.
package wsts_pkg;

  localparam int WORKERS_DEF     = 2;
  localparam int DEQUE_DEPTH_DEF = 32;
  localparam int TASK_SLOTS_DEF  = 16;

  localparam logic [5:0]  MAX_TARGET = 6'd46;
  localparam logic [15:0] STAT_MAX   = 16'hFFFF;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [1:0] KIND_PUSH_OK   = 2'd0;
  localparam logic [1:0] KIND_PUSH_FULL = 2'd1;
  localparam logic [1:0] KIND_TICK      = 2'd2;
  localparam logic [1:0] KIND_IDLE      = 2'd3;

  typedef struct packed {
    logic [5:0]  target;
    logic [5:0]  progress;
    logic [31:0] fib_low;
    logic [31:0] fib_high;
  } task_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        worker;
    logic [3:0]  task_id;
    logic        stolen;
    logic        finished;
    logic [30:0] fib_value;
    logic [15:0] ticks;
    logic [15:0] steals;
  } res_t;

endpackage

### rtl/core/wsts_deque_mem.sv
// Ring storage for all worker deques, one synchronous memory.
// Depends on wsts_pkg.
module wsts_deque_mem
  import wsts_pkg::*;
#(
  parameter int AW = 6,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/wsts_task_mem.sv
// Per-task state memory: target, progress and the Fibonacci pair.
// Depends on wsts_pkg for task_t.
module wsts_task_mem
  import wsts_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output task_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  task_t         wr_data
);

  task_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/work_stealing_task_scheduler_unit.sv
// A push transaction passes through S_PUSH, and its result strobe is registered. A round
// visits S_PICK, S_DQ and S_TK for each worker that runs a task and S_PICK alone for each
// worker with nothing to do, then S_OUT once for each result. The deque and task memories,
// which every visit reads in turn, have registered reads. Results come one per cycle with
// out_valid and cannot be held off; busy falls in the cycle that carries the last result of
// a transaction, so the next transaction can be accepted at the edge that ends it. No
// clearing pass follows reset.
// Depends on wsts_pkg, wsts_deque_mem and wsts_task_mem.
module work_stealing_task_scheduler_unit
  import wsts_pkg::*;
#(
  parameter int WORKERS     = WORKERS_DEF,
  parameter int DEQUE_DEPTH = DEQUE_DEPTH_DEF,
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic        in_worker,
  input  logic [3:0]  in_task_id,
  input  logic [5:0]  in_target_index,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic        out_worker_res,
  output logic [3:0]  out_task_id_res,
  output logic        out_stolen,
  output logic        out_finished,
  output logic [30:0] out_fib_value,
  output logic [15:0] out_worker_ticks,
  output logic [15:0] out_worker_steals,
  output logic        out_deques_empty,
  output logic        out_last
);

  localparam int WW = $clog2(WORKERS);
  localparam int PW = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
  localparam int FW = $clog2(DEQUE_DEPTH + 1);
  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int AW = $clog2(WORKERS * DEQUE_DEPTH);
  localparam int RW = $clog2(WORKERS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PUSH = 6'b000010,
    S_PICK = 6'b000100,
    S_DQ   = 6'b001000,
    S_TK   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r [WORKERS];
  logic [PW-1:0] head_nxt [WORKERS];
  logic [PW-1:0] tail_r [WORKERS];
  logic [PW-1:0] tail_nxt [WORKERS];
  logic [FW-1:0] fill_r [WORKERS];
  logic [FW-1:0] fill_nxt [WORKERS];
  logic [15:0]   ticks_r [WORKERS];
  logic [15:0]   ticks_nxt [WORKERS];
  logic [15:0]   steals_r [WORKERS];
  logic [15:0]   steals_nxt [WORKERS];

  logic          pw_r, pw_nxt;
  logic [TW-1:0] pid_r, pid_nxt;
  logic [5:0]    ptgt_r, ptgt_nxt;
  logic [WW-1:0] wsel_r, wsel_nxt;
  logic          stole_r, stole_nxt;
  logic [RW-1:0] res_cnt_r, res_cnt_nxt;
  logic [RW-1:0] out_idx_r, out_idx_nxt;
  res_t          rbuf_r [WORKERS];
  res_t          rbuf_wdata;
  logic          rbuf_we;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;
  logic          out_idle_r, out_idle_nxt;
  logic          out_last_r, out_last_nxt;

  logic          dq_rd_en, dq_wr_en;
  logic [AW-1:0] dq_rd_addr, dq_wr_addr;
  logic [TW-1:0] dq_rd_data, dq_wr_data;
  logic          tk_rd_en, tk_wr_en;
  logic [TW-1:0] tk_rd_addr, tk_wr_addr, id_r, id_nxt;
  task_t         tk_rd_data, tk_wr_data;

  logic [TW-1:0] id_map [16];

  for (genvar i = 0; i < 16; i++) begin : g_idmap
    assign id_map[i] = TW'(i % TASK_SLOTS);
  end

  function automatic logic [AW-1:0] daddr(input logic [WW-1:0] w, input logic [PW-1:0] p);
    return AW'(AW'(w) * AW'(DEQUE_DEPTH) + AW'(p));
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEQUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEQUE_DEPTH - 1) : PW'(p - 1'b1);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == STAT_MAX) ? v : 16'(v + 1'b1);
  endfunction

  function automatic logic [3:0] id4(input logic [TW-1:0] id);
    logic [7:0] t;
    t = 8'(id);
    return t[3:0];
  endfunction

  wsts_deque_mem #(.AW(AW), .DW(TW)) u_deque (
    .clk    (clk),
    .rd_en  (dq_rd_en),
    .rd_addr(dq_rd_addr),
    .rd_data(dq_rd_data),
    .wr_en  (dq_wr_en),
    .wr_addr(dq_wr_addr),
    .wr_data(dq_wr_data)
  );

  wsts_task_mem #(.AW(TW)) u_task (
    .clk    (clk),
    .rd_en  (tk_rd_en),
    .rd_addr(tk_rd_addr),
    .rd_data(tk_rd_data),
    .wr_en  (tk_wr_en),
    .wr_addr(tk_wr_addr),
    .wr_data(tk_wr_data)
  );

  always_comb begin
    logic          found;
    logic [WW-1:0] vic;
    logic          fin;
    logic [31:0]   sum;
    logic          all_empty;
    task_t         t;
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    ticks_nxt     = ticks_r;
    steals_nxt    = steals_r;
    pw_nxt        = pw_r;
    pid_nxt       = pid_r;
    ptgt_nxt      = ptgt_r;
    wsel_nxt      = wsel_r;
    stole_nxt     = stole_r;
    res_cnt_nxt   = res_cnt_r;
    out_idx_nxt   = out_idx_r;
    id_nxt        = id_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    out_idle_nxt  = out_idle_r;
    out_last_nxt  = out_last_r;
    dq_rd_en      = 1'b0;
    dq_rd_addr    = '0;
    dq_wr_en      = 1'b0;
    dq_wr_addr    = '0;
    dq_wr_data    = '0;
    tk_rd_en      = 1'b0;
    tk_rd_addr    = '0;
    tk_wr_en      = 1'b0;
    tk_wr_addr    = '0;
    tk_wr_data    = '0;
    rbuf_we       = 1'b0;
    rbuf_wdata    = '0;
    found         = 1'b0;
    vic           = '0;
    fin           = 1'b0;
    sum           = '0;
    t             = tk_rd_data;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          pw_nxt      = in_worker;
          pid_nxt     = id_map[in_task_id];
          ptgt_nxt    = (in_target_index > MAX_TARGET) ? MAX_TARGET : in_target_index;
          wsel_nxt    = '0;
          res_cnt_nxt = '0;
          out_idx_nxt = '0;
          state_nxt   = (in_func == FUNC_PUSH) ? S_PUSH : S_PICK;
        end
      end
      S_PUSH: begin
        out_valid_nxt          = 1'b1;
        out_res_nxt            = '0;
        out_res_nxt.worker     = pw_r;
        out_res_nxt.task_id    = id4(pid_r);
        out_res_nxt.ticks      = ticks_r[WW'(pw_r)];
        out_res_nxt.steals     = steals_r[WW'(pw_r)];
        out_res_nxt.kind       = KIND_PUSH_FULL;
        out_last_nxt           = 1'b1;
        if (fill_r[WW'(pw_r)] < FW'(DEQUE_DEPTH)) begin
          out_res_nxt.kind        = KIND_PUSH_OK;
          tk_wr_en                = 1'b1;
          tk_wr_addr              = pid_r;
          tk_wr_data.target       = ptgt_r;
          tk_wr_data.progress     = '0;
          tk_wr_data.fib_low      = 32'd0;
          tk_wr_data.fib_high     = 32'd1;
          dq_wr_en                = 1'b1;
          dq_wr_addr              = daddr(WW'(pw_r), tail_r[WW'(pw_r)]);
          dq_wr_data              = pid_r;
          tail_nxt[WW'(pw_r)]     = ptr_inc(tail_r[WW'(pw_r)]);
          fill_nxt[WW'(pw_r)]     = FW'(fill_r[WW'(pw_r)] + 1'b1);
        end
        state_nxt = S_IDLE;
      end
      S_PICK: begin
        for (int v = 0; v < WORKERS; v++) begin
          if (!found && WW'(v) != wsel_r && fill_r[v] != '0) begin
            found = 1'b1;
            vic   = WW'(v);
          end
        end
        if (fill_r[wsel_r] != '0) begin
          dq_rd_en           = 1'b1;
          dq_rd_addr         = daddr(wsel_r, head_r[wsel_r]);
          head_nxt[wsel_r]   = ptr_inc(head_r[wsel_r]);
          fill_nxt[wsel_r]   = FW'(fill_r[wsel_r] - 1'b1);
          ticks_nxt[wsel_r]  = sat_inc(ticks_r[wsel_r]);
          stole_nxt          = 1'b0;
          state_nxt          = S_DQ;
        end else if (found) begin
          dq_rd_en           = 1'b1;
          dq_rd_addr         = daddr(vic, ptr_dec(tail_r[vic]));
          tail_nxt[vic]      = ptr_dec(tail_r[vic]);
          fill_nxt[vic]      = FW'(fill_r[vic] - 1'b1);
          ticks_nxt[wsel_r]  = sat_inc(ticks_r[wsel_r]);
          steals_nxt[wsel_r] = sat_inc(steals_r[wsel_r]);
          stole_nxt          = 1'b1;
          state_nxt          = S_DQ;
        end else if (wsel_r == WW'(WORKERS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          wsel_nxt = WW'(wsel_r + 1'b1);
        end
      end
      S_DQ: begin
        tk_rd_en   = 1'b1;
        tk_rd_addr = dq_rd_data;
        id_nxt     = dq_rd_data;
        state_nxt  = S_TK;
      end
      S_TK: begin
        if (tk_rd_data.progress >= tk_rd_data.target) begin
          fin = 1'b1;
        end else begin
          sum        = tk_rd_data.fib_low + tk_rd_data.fib_high;
          t.fib_low  = tk_rd_data.fib_high;
          t.fib_high = sum;
          t.progress = 6'(tk_rd_data.progress + 1'b1);
          fin        = (t.progress >= tk_rd_data.target);
        end
        tk_wr_en   = 1'b1;
        tk_wr_addr = id_r;
        tk_wr_data = t;
        if (!fin) begin
          dq_wr_en         = 1'b1;
          dq_wr_addr       = daddr(wsel_r, tail_r[wsel_r]);
          dq_wr_data       = id_r;
          tail_nxt[wsel_r] = ptr_inc(tail_r[wsel_r]);
          fill_nxt[wsel_r] = FW'(fill_r[wsel_r] + 1'b1);
        end
        rbuf_we             = 1'b1;
        rbuf_wdata.kind     = KIND_TICK;
        rbuf_wdata.worker   = wsel_r[0];
        rbuf_wdata.task_id  = id4(id_r);
        rbuf_wdata.stolen   = stole_r;
        rbuf_wdata.finished = fin;
        rbuf_wdata.fib_value = t.fib_low[30:0];
        rbuf_wdata.ticks    = ticks_r[wsel_r];
        rbuf_wdata.steals   = steals_r[wsel_r];
        res_cnt_nxt         = RW'(res_cnt_r + 1'b1);
        if (wsel_r == WW'(WORKERS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          wsel_nxt  = WW'(wsel_r + 1'b1);
          state_nxt = S_PICK;
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (res_cnt_r == '0) begin
          out_res_nxt      = '0;
          out_res_nxt.kind = KIND_IDLE;
          out_last_nxt     = 1'b1;
        end else begin
          out_res_nxt  = rbuf_r[WW'(out_idx_r)];
          out_last_nxt = (out_idx_r == RW'(res_cnt_r - 1'b1));
        end
        out_idx_nxt = RW'(out_idx_r + 1'b1);
        if (out_last_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    all_empty = 1'b1;
    for (int w = 0; w < WORKERS; w++) begin
      if (fill_nxt[w] != '0) begin
        all_empty = 1'b0;
      end
    end
    if (out_valid_nxt) begin
      out_idle_nxt = all_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int w = 0; w < WORKERS; w++) begin
        head_r[w]   <= '0;
        tail_r[w]   <= '0;
        fill_r[w]   <= '0;
        ticks_r[w]  <= '0;
        steals_r[w] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      ticks_r     <= ticks_nxt;
      steals_r    <= steals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r       <= pw_nxt;
    pid_r      <= pid_nxt;
    ptgt_r     <= ptgt_nxt;
    wsel_r     <= wsel_nxt;
    stole_r    <= stole_nxt;
    res_cnt_r  <= res_cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    id_r       <= id_nxt;
    out_res_r  <= out_res_nxt;
    out_idle_r <= out_idle_nxt;
    out_last_r <= out_last_nxt;
    if (rbuf_we) begin
      rbuf_r[WW'(res_cnt_r)] <= rbuf_wdata;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_worker_res    = out_res_r.worker;
  assign out_task_id_res   = out_res_r.task_id;
  assign out_stolen        = out_res_r.stolen;
  assign out_finished      = out_res_r.finished;
  assign out_fib_value     = out_res_r.fib_value;
  assign out_worker_ticks  = out_res_r.ticks;
  assign out_worker_steals = out_res_r.steals;
  assign out_deques_empty  = out_idle_r;
  assign out_last          = out_last_r;

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("Result strobe directly after the final result of a transaction.");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_IDLE |-> out_deques_empty && out_last)
    else $error("Idle result without an empty pool or not final.");

  for (genvar w = 0; w < WORKERS; w++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[w] <= FW'(DEQUE_DEPTH))
      else $error("Deque fill count exceeds its depth.");
  end

endmodule
